FILE: hw/rtl/positional_array_list_core_defines.svh
// assertion macros shared by the positional array list rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PAL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pal assertion failed");

`define PAL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pal implication failed");

`else

`define PAL_ASSERT(name, clk, rst, prop)

`define PAL_ASSERT_IMP(name, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/pal_pkg.sv
// types and fixed constants for the positional array list core
// no dependencies
package pal_pkg;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int TRAV_MAX = 16;

   typedef enum logic [1:0] {
      REQ_INSERT   = 2'd0,
      REQ_DELETE   = 2'd1,
      REQ_SEARCH   = 2'd2,
      REQ_TRAVERSE = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_BAD_POS   = 3'd1,
      STS_FULL      = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_DELETE,
      ST_SCAN,
      ST_WALK
   } state_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_UP,
      WR_DOWN,
      WR_KEY
   } wr_kind_type;

   typedef struct packed {
      logic         load;
      req_kind_type load_mode;
      logic         issue;
      logic         dir_down;
      wr_kind_type  wr_kind;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         emit;
      status_type   emit_status;
      logic         emit_from_rd;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_gt_cnt;
      logic pos_ge_cnt;
      logic left_zero;
      logic rd_vld;
      logic rd_last;
      logic hit;
   } sts_type;

endpackage

FILE: hw/rtl/pal_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pal_datapath.sv
// datapath: entry ram, count, sweep pointer, read stage and result register
// depends on pal_pkg, pal_ram and positional_array_list_core_defines.svh
`include "positional_array_list_core_defines.svh"

module pal_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pal_pkg::cmd_type                   cmd,
   output pal_pkg::sts_type                   sts,
   input  logic [pal_pkg::POS_W-1:0]          req_position,
   input  logic signed [pal_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_strobe,
   output logic [pal_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pal_pkg::INDEX_W-1:0]        rsp_index,
   output logic signed [pal_pkg::DATA_W-1:0]  rsp_data,
   output logic                               rsp_last
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   left_ff, left_in;
   logic [AW-1:0]                   ptr_ff, ptr_in;
   logic [AW-1:0]                   pos_ff, pos_in;
   logic [AW-1:0]                   rd_idx_ff, rd_idx_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic                            rd_last_ff, rd_last_in;
   logic signed [pal_pkg::DATA_W-1:0] key_ff, key_in;

   logic                            rsp_strobe_ff, rsp_strobe_in;
   pal_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [pal_pkg::INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [pal_pkg::DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [CMPW-1:0]                 cnt_w, pos_w;
   logic                            issue;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [pal_pkg::DATA_W-1:0]      wr_data;
   logic [pal_pkg::DATA_W-1:0]      rd_data;

   assign cnt_w = CMPW'(count_ff);
   assign pos_w = CMPW'(req_position);
   assign issue = cmd.issue && (left_ff != '0);

   pal_ram #(
      .WIDTH (pal_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // sweep pointer and remaining read count
   always_comb begin
      ptr_in     = ptr_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      rd_vld_in  = issue;
      rd_idx_in  = ptr_ff;
      rd_last_in = (left_ff == CW'(1));
      if (cmd.load) begin
         key_in = req_value;
         pos_in = AW'(pos_w);
         case (cmd.load_mode)
            pal_pkg::REQ_INSERT: begin
               ptr_in  = AW'(cnt_w - CMPW'(1));
               left_in = CW'(cnt_w - pos_w);
            end
            pal_pkg::REQ_DELETE: begin
               ptr_in  = AW'(pos_w + CMPW'(1));
               left_in = CW'(cnt_w - pos_w - CMPW'(1));
            end
            pal_pkg::REQ_SEARCH: begin
               ptr_in  = '0;
               left_in = count_ff;
            end
            default: begin
               ptr_in  = '0;
               left_in = (32'(count_ff) > 32'(pal_pkg::TRAV_MAX)) ?
                         CW'(pal_pkg::TRAV_MAX) : count_ff;
            end
         endcase
      end else if (issue) begin
         ptr_in  = cmd.dir_down ? (ptr_ff - 1'b1) : (ptr_ff + 1'b1);
         left_in = left_ff - 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   // single ram write port: shifted word or the inserted word
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data;
      case (cmd.wr_kind)
         pal_pkg::WR_UP: begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff + 1'b1;
         end
         pal_pkg::WR_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff - 1'b1;
         end
         pal_pkg::WR_KEY: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = key_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_strobe_in = cmd.emit;
      rsp_status_in = cmd.emit_status;
      rsp_last_in   = cmd.emit_last;
      rsp_index_in  = cmd.emit_from_rd ? pal_pkg::INDEX_W'(rd_idx_ff) : '0;
      rsp_data_in   = cmd.emit_from_rd ? rd_data : '0;
   end

   always_comb begin
      sts.full       = (count_ff == CW'(DEPTH));
      sts.empty      = (count_ff == '0);
      sts.pos_gt_cnt = (pos_w > cnt_w);
      sts.pos_ge_cnt = (pos_w >= cnt_w);
      sts.left_zero  = (left_ff == '0);
      sts.rd_vld     = rd_vld_ff;
      sts.rd_last    = rd_last_ff;
      sts.hit        = rd_vld_ff && (rd_data == key_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      rd_idx_ff     <= rd_idx_in;
      rd_last_ff    <= rd_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

   `PAL_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `PAL_ASSERT(a_count_step, clock, reset, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) || (count_ff + 1'b1 == $past(count_ff)))
   `PAL_ASSERT_IMP(a_key_after_shift, clock, reset, cmd.wr_kind == pal_pkg::WR_KEY, !rd_vld_ff && (left_ff == '0))
   `PAL_ASSERT_IMP(a_read_in_list, clock, reset, rd_vld_ff, CW'(rd_idx_ff) < count_ff)

endmodule

FILE: hw/rtl/pal_ctrl.sv
// controller state machine: request decode, rejections and sweep sequencing
// depends on pal_pkg
module pal_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [1:0]                  req_type,
   input  pal_pkg::sts_type            sts,
   output pal_pkg::cmd_type            cmd,
   output logic                        busy
);

   pal_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pal_pkg::ST_IDLE: begin
            if (start) begin
               case (req_type)
                  pal_pkg::REQ_INSERT: begin
                     if (!sts.full && !sts.pos_gt_cnt) begin
                        state_in = pal_pkg::ST_INSERT;
                     end
                  end
                  pal_pkg::REQ_DELETE: begin
                     if (!sts.empty && !sts.pos_ge_cnt) begin
                        state_in = pal_pkg::ST_DELETE;
                     end
                  end
                  pal_pkg::REQ_SEARCH: begin
                     if (!sts.empty) begin
                        state_in = pal_pkg::ST_SCAN;
                     end
                  end
                  pal_pkg::REQ_TRAVERSE: begin
                     if (!sts.empty) begin
                        state_in = pal_pkg::ST_WALK;
                     end
                  end
                  default: begin
                     state_in = pal_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         pal_pkg::ST_INSERT: begin
            if (!sts.rd_vld && sts.left_zero) begin
               state_in = pal_pkg::ST_IDLE;
            end
         end
         pal_pkg::ST_DELETE: begin
            if (!sts.rd_vld && sts.left_zero) begin
               state_in = pal_pkg::ST_IDLE;
            end
         end
         pal_pkg::ST_SCAN: begin
            if (sts.rd_vld && (sts.hit || sts.rd_last)) begin
               state_in = pal_pkg::ST_IDLE;
            end
         end
         pal_pkg::ST_WALK: begin
            if (sts.rd_vld && sts.rd_last) begin
               state_in = pal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pal_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.load_mode   = pal_pkg::REQ_INSERT;
      cmd.wr_kind     = pal_pkg::WR_NONE;
      cmd.emit_status = pal_pkg::STS_OK;
      busy            = 1'b1;
      case (state_ff)
         pal_pkg::ST_IDLE: begin
            busy          = 1'b0;
            cmd.emit_last = 1'b1;
            if (start) begin
               cmd.load      = 1'b1;
               cmd.load_mode = pal_pkg::req_kind_type'(req_type);
               case (req_type)
                  pal_pkg::REQ_INSERT: begin
                     if (sts.full) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = pal_pkg::STS_FULL;
                     end else if (sts.pos_gt_cnt) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = pal_pkg::STS_BAD_POS;
                     end
                  end
                  pal_pkg::REQ_DELETE: begin
                     if (sts.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = pal_pkg::STS_EMPTY;
                     end else if (sts.pos_ge_cnt) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = pal_pkg::STS_BAD_POS;
                     end
                  end
                  default: begin
                     if (sts.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = pal_pkg::STS_EMPTY;
                     end
                  end
               endcase
            end
         end
         pal_pkg::ST_INSERT: begin
            // walk down from the tail, each word lands one slot higher
            cmd.issue    = 1'b1;
            cmd.dir_down = 1'b1;
            if (sts.rd_vld) begin
               cmd.wr_kind = pal_pkg::WR_UP;
            end else if (sts.left_zero) begin
               cmd.wr_kind   = pal_pkg::WR_KEY;
               cmd.cnt_inc   = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
            end
         end
         pal_pkg::ST_DELETE: begin
            cmd.issue = 1'b1;
            if (sts.rd_vld) begin
               cmd.wr_kind = pal_pkg::WR_DOWN;
            end else if (sts.left_zero) begin
               cmd.cnt_dec   = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
            end
         end
         pal_pkg::ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.rd_vld && (sts.hit || sts.rd_last)) begin
               cmd.issue        = 1'b0;
               cmd.emit         = 1'b1;
               cmd.emit_last    = 1'b1;
               cmd.emit_from_rd = sts.hit;
               cmd.emit_status  = sts.hit ? pal_pkg::STS_OK : pal_pkg::STS_NOT_FOUND;
            end
         end
         pal_pkg::ST_WALK: begin
            cmd.issue = 1'b1;
            if (sts.rd_vld) begin
               cmd.emit         = 1'b1;
               cmd.emit_from_rd = 1'b1;
               cmd.emit_last    = sts.rd_last;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pal_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/positional_array_list_core.sv
// ordered list of signed words in a ram; entries move one word a cycle
// rejected requests, search and traverse on an empty list: word the cycle after start
// insert at p shifts entries p..count-1 up one slot; delete at p shifts p+1..count-1 down
// search stops at the first hit; traverse emits n = min(count, 16) words
// last word in the same cycle busy drops; receiver cannot stall; one item at a time (ram ports)
// reset empties the list at once; entry contents are not cleared
module positional_array_list_core #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic [pal_pkg::POS_W-1:0]          req_position,
   input  logic signed [pal_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_strobe,
   output logic [pal_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pal_pkg::INDEX_W-1:0]        rsp_index,
   output logic signed [pal_pkg::DATA_W-1:0]  rsp_data,
   output logic                               rsp_last
);

   pal_pkg::cmd_type cmd;
   pal_pkg::sts_type sts;

   pal_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   pal_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_index    (rsp_index),
      .rsp_data     (rsp_data),
      .rsp_last     (rsp_last)
   );

endmodule
